### src/wps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wash program sequencer.
// No dependencies; imported by the sequencer core.
package wps_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned PROGRAMS_DEF = 4;
	localparam int unsigned STEPS_DEF    = 16;

	// Step table geometry, fixed by the 6-bit entry address
	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned TABLE_AW    = 6;
	localparam int unsigned ADDR_SUM_W  = 10;

	localparam int unsigned MASK_W     = 16;
	localparam int unsigned DUR_W      = 32;
	localparam int unsigned ROT_TICK_W = 16;
	localparam int unsigned PROG_W     = 2;
	localparam int unsigned STEP_NUM_W = 5;
	localparam int unsigned STATUS_W   = 3;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_TDATA_W  = 56;
	localparam int unsigned S_TUSER_W  = 2;
	localparam int unsigned M_TDATA_W  = 32;

	// Register reset values
	localparam logic [PROG_W-1:0]     PROGRAM_SELECT_RST = '0;
	localparam logic [ROT_TICK_W-1:0] RUN_TICKS_RST      = 16'd300;
	localparam logic [ROT_TICK_W-1:0] PAUSE_TICKS_RST    = 16'd100;
	localparam logic [MASK_W-1:0]     MOTOR_MASK_RST     = 16'h4000;
	localparam logic [MASK_W-1:0]     REVERSE_MASK_RST   = 16'h8000;
	localparam logic [MASK_W-1:0]     DRIVE_ALL_OFF      = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_ABORT = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROGRAM_SELECT = 3'd0,
		CFG_RUN_TICKS      = 3'd1,
		CFG_PAUSE_TICKS    = 3'd2,
		CFG_MOTOR_MASK     = 3'd3,
		CFG_REVERSE_MASK   = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ROT_NONE     = 5'b00001,
		ROT_FORWARD  = 5'b00010,
		ROT_REVERSE  = 5'b00100,
		ROT_PAUSE    = 5'b01000,
		ROT_STOPPING = 5'b10000
	} rot_state_t;

	localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FORWARD  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_REVERSE  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_PAUSE    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_STOPPING = 3'd4;

	typedef struct packed {
		logic [DUR_W-1:0]  duration;
		logic [MASK_W-1:0] mask;
		logic              rotation;
		logic              end_flag;
	} step_entry_t;

	localparam int unsigned ENTRY_W = $bits(step_entry_t);

	function automatic logic [STATUS_W-1:0] rot_status(input rot_state_t s);
		case (s)
			ROT_NONE:     rot_status = STAT_NONE;
			ROT_FORWARD:  rot_status = STAT_FORWARD;
			ROT_REVERSE:  rot_status = STAT_REVERSE;
			ROT_PAUSE:    rot_status = STAT_PAUSE;
			ROT_STOPPING: rot_status = STAT_STOPPING;
			default:      rot_status = STAT_NONE;
		endcase
	endfunction

endpackage

### src/wps_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the step table of the sequencer.
module wps_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/wash_program_sequencer_core.sv
`timescale 1ns / 1ps
// Wash program sequencer core: step table, wash step and drum rotation control.
// Depends on wps_pkg and wps_ram.
//
// Channel   Dir  Handshake                      Word contents (low bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: operation; tdata: entry fields
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: drive_lines, washing, step, status
// cfg       in   cfg_valid/cfg_ready            cfg_index selects register, cfg_data value
//
// Every input word yields one result word; one word is taken per cycle unless
// stalled, and the registered result appears on m_axis in the cycle after
// acceptance. Step table reads use the next-state step address, so the tick
// path sees the entry straight from the RAM read register (or a write bypass).
// Reset clears all control state; drive lines come up all off (all ones).
// The input side stalls only while a result is held and m_axis_tready is low.
module wash_program_sequencer_core
	import wps_pkg::*;
#(
	parameter int unsigned PROGRAMS = PROGRAMS_DEF,
	parameter int unsigned STEPS    = STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [55:24] entry_duration, [23:8] entry_mask, [7] entry_rotation,
	// [6] entry_end, [5:0] entry_address (lowest bit first: address, end,
	// rotation, mask, duration)
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [S_TUSER_W-1:0]  s_axis_tuser,
	// result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] drive_lines, [16] washing, [21:17] step_number,
	// [24:22] rotation_status, [31:25] zero
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Step index must be able to hold STEPS itself (the cap)
	localparam int unsigned IDX_W = $clog2(STEPS + 1);

	// Handshakes
	logic accept;
	logic cfg_we;

	// Unpacked input word
	op_t                 op;
	logic [TABLE_AW-1:0] in_address;
	step_entry_t         in_entry;

	// Configuration registers
	logic [PROG_W-1:0]     prog_q;
	logic [PROG_W-1:0]     prog_d;
	logic [ROT_TICK_W-1:0] run_q;
	logic [ROT_TICK_W-1:0] pause_q;
	logic [MASK_W-1:0]     motor_q;
	logic [MASK_W-1:0]     reverse_q;

	// Sequencer state and its next values
	logic                  active_q, active_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [DUR_W-1:0]      wc_q, wc_d;
	rot_state_t            rot_q, rot_d;
	rot_state_t            ap_q, ap_d;
	logic [ROT_TICK_W-1:0] rc_q, rc_d;
	logic [MASK_W-1:0]     mask_q, mask_d;
	logic [MASK_W-1:0]     drive_q, drive_d;

	// Step table access
	logic [PROG_W-1:0]     prog_mod;
	logic [ADDR_SUM_W-1:0] addr_sum;
	logic [TABLE_AW-1:0]   raddr;
	logic                  table_we;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic                  byp_q;
	step_entry_t           byp_entry_q;
	step_entry_t           entry;

	// Result register
	logic                  m_valid_q;
	logic [M_TDATA_W-1:0]  m_data_q;

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_we        = cfg_valid && cfg_ready;

	assign op                = op_t'(s_axis_tuser);
	assign in_address        = s_axis_tdata[5:0];
	assign in_entry.end_flag = s_axis_tdata[6];
	assign in_entry.rotation = s_axis_tdata[7];
	assign in_entry.mask     = s_axis_tdata[23:8];
	assign in_entry.duration = s_axis_tdata[55:24];

	// Configuration port
	assign prog_d = (cfg_we && cfg_index == CFG_PROGRAM_SELECT) ? cfg_data[PROG_W-1:0] : prog_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q    <= PROGRAM_SELECT_RST;
			run_q     <= RUN_TICKS_RST;
			pause_q   <= PAUSE_TICKS_RST;
			motor_q   <= MOTOR_MASK_RST;
			reverse_q <= REVERSE_MASK_RST;
		end else begin
			prog_q <= prog_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_RUN_TICKS:    run_q     <= cfg_data;
					CFG_PAUSE_TICKS:  pause_q   <= cfg_data;
					CFG_MOTOR_MASK:   motor_q   <= cfg_data;
					CFG_REVERSE_MASK: reverse_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Step table: read address follows the next-state program and step, so the
	// entry is ready in the read register when the following word arrives.
	always_comb begin
		if (PROGRAMS == 1) begin
			prog_mod = '0;
		end else if (32'(prog_d) >= PROGRAMS) begin
			prog_mod = PROG_W'(32'(prog_d) - PROGRAMS);
		end else begin
			prog_mod = prog_d;
		end
	end

	assign addr_sum = ADDR_SUM_W'(prog_mod) * ADDR_SUM_W'(STEPS) + ADDR_SUM_W'(idx_d);
	assign raddr    = addr_sum[TABLE_AW-1:0];
	assign table_we = accept && op == OP_WRITE;

	wps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (table_we),
		.waddr(in_address),
		.wdata(in_entry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Bypass a write that lands on the address being fetched this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= table_we && in_address == raddr;
		end
	end

	always_ff @(posedge clk) begin
		byp_entry_q <= in_entry;
	end

	assign entry = byp_q ? byp_entry_q : step_entry_t'(ram_rdata);

	// Next-state logic for one word
	always_comb begin
		active_d = active_q;
		idx_d    = idx_q;
		wc_d     = wc_q;
		rot_d    = rot_q;
		ap_d     = ap_q;
		rc_d     = rc_q;
		mask_d   = mask_q;
		drive_d  = drive_q;
		if (accept) begin
			case (op)
				OP_TICK: begin
					// Count both timers down, holding at zero
					if (wc_q != '0) begin
						wc_d = wc_q - 1'b1;
					end
					if (rc_q != '0) begin
						rc_d = rc_q - 1'b1;
					end
					// Wash step: once the step time is spent, load the next entry or stop at the cap or an end flag
					if (active_q && wc_d == '0) begin
						if (idx_q >= IDX_W'(STEPS)) begin
							active_d = 1'b0;
						end else if (entry.end_flag) begin
							active_d = 1'b0;
						end else begin
							rot_d   = entry.rotation ? ROT_FORWARD : ROT_STOPPING;
							mask_d  = entry.mask;
							drive_d = ~entry.mask;
							wc_d    = entry.duration;
							idx_d   = IDX_W'(idx_q + 1'b1);
						end
					end
					// Drum rotation: forward, pause, reverse, pause, or stopping to none
					if ((rc_d == '0 && rot_d != ROT_NONE) || rot_d == ROT_STOPPING) begin
						case (rot_d)
							ROT_FORWARD: begin
								drive_d = ~(mask_d | motor_q);
								rc_d    = run_q;
								rot_d   = ROT_PAUSE;
								ap_d    = ROT_REVERSE;
							end
							ROT_REVERSE: begin
								drive_d = ~(mask_d | motor_q | reverse_q);
								rc_d    = run_q;
								rot_d   = ROT_PAUSE;
								ap_d    = ROT_FORWARD;
							end
							ROT_PAUSE: begin
								drive_d = ~mask_d;
								rc_d    = pause_q;
								rot_d   = ap_q;
							end
							ROT_STOPPING: begin
								drive_d = ~mask_d;
								rot_d   = ROT_NONE;
							end
							default: ;
						endcase
					end
				end
				OP_START: begin
					idx_d    = '0;
					active_d = 1'b1;
				end
				OP_ABORT: begin
					// Drop the program and force every line off
					active_d = 1'b0;
					rot_d    = ROT_STOPPING;
					wc_d     = '0;
					mask_d   = '0;
					drive_d  = DRIVE_ALL_OFF;
				end
				OP_WRITE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			wc_q     <= '0;
			rot_q    <= ROT_NONE;
			ap_q     <= ROT_NONE;
			rc_q     <= '0;
			mask_q   <= '0;
			drive_q  <= DRIVE_ALL_OFF;
		end else begin
			active_q <= active_d;
			idx_q    <= idx_d;
			wc_q     <= wc_d;
			rot_q    <= rot_d;
			ap_q     <= ap_d;
			rc_q     <= rc_d;
			mask_q   <= mask_d;
			drive_q  <= drive_d;
		end
	end

	// Result register: hold until taken, reload on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {7'b0, rot_status(rot_d), STEP_NUM_W'(idx_d), active_d, drive_d};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### dv/wash_sequencer_checker.sv
`timescale 1ns / 1ps
// Result checker for the wash program sequencer: tracks the sequencer state from
// the accepted words, predicts one result word per input word and compares.
// Depends on wps_pkg.
module wash_sequencer_checker
	import wps_pkg::*;
#(
	parameter int unsigned PROGRAMS = PROGRAMS_DEF,
	parameter int unsigned STEPS    = STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	input  logic [S_TUSER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    outstanding,
	output int                    mismatches
);

	typedef struct packed {
		logic [6:0]            pad;
		logic [STATUS_W-1:0]   status;
		logic [STEP_NUM_W-1:0] step;
		logic                  washing;
		logic [MASK_W-1:0]     drive;
	} result_word_t;

	step_entry_t               program_table [TABLE_DEPTH];
	logic                      running;
	logic [STEP_NUM_W-1:0]     next_step;
	logic [DUR_W-1:0]          step_left;
	logic [STATUS_W-1:0]       drum;
	logic [STATUS_W-1:0]       drum_after;
	logic [ROT_TICK_W-1:0]     drum_left;
	logic [MASK_W-1:0]         step_mask;
	logic [MASK_W-1:0]         lines;

	logic [PROG_W-1:0]         prog_sel;
	logic [ROT_TICK_W-1:0]     run_len;
	logic [ROT_TICK_W-1:0]     pause_len;
	logic [MASK_W-1:0]         motor_bits;
	logic [MASK_W-1:0]         reverse_bits;

	result_word_t              expected_words [$];
	int                        errors;

	task automatic advance_program();
		step_entry_t ent;
		logic [TABLE_AW-1:0] slot;
		if (!running || step_left != 0)
			return;
		if (next_step >= STEPS) begin
			running = 1'b0;
			return;
		end
		slot = TABLE_AW'(((prog_sel % PROGRAMS) * STEPS + next_step) % TABLE_DEPTH);
		ent = program_table[slot];
		if (ent.end_flag) begin
			running = 1'b0;
			return;
		end
		drum = ent.rotation ? STAT_FORWARD : STAT_STOPPING;
		step_mask = ent.mask;
		lines = ~ent.mask;
		step_left = ent.duration;
		next_step = next_step + 1'b1;
	endtask

	task automatic advance_drum();
		if (!((drum_left == 0 && drum != STAT_NONE) || drum == STAT_STOPPING))
			return;
		case (drum)
			STAT_FORWARD: begin
				lines = ~(step_mask | motor_bits);
				drum_left = run_len;
				drum = STAT_PAUSE;
				drum_after = STAT_REVERSE;
			end
			STAT_REVERSE: begin
				lines = ~(step_mask | motor_bits | reverse_bits);
				drum_left = run_len;
				drum = STAT_PAUSE;
				drum_after = STAT_FORWARD;
			end
			STAT_PAUSE: begin
				lines = ~step_mask;
				drum_left = pause_len;
				drum = {1'b0, drum_after[1:0]};
			end
			STAT_STOPPING: begin
				lines = ~step_mask;
				drum = STAT_NONE;
			end
			default: ;
		endcase
	endtask

	task automatic apply_word(input op_t op, input logic [S_TDATA_W-1:0] payload,
			output result_word_t res);
		case (op)
			OP_TICK: begin
				if (step_left != 0)
					step_left = step_left - 1'b1;
				if (drum_left != 0)
					drum_left = drum_left - 1'b1;
				advance_program();
				advance_drum();
			end
			OP_START: begin
				next_step = '0;
				running = 1'b1;
			end
			OP_ABORT: begin
				running = 1'b0;
				drum = STAT_STOPPING;
				step_left = '0;
				step_mask = '0;
				lines = DRIVE_ALL_OFF;
			end
			default: begin
				program_table[payload[TABLE_AW-1:0]] = payload[S_TDATA_W-1:TABLE_AW];
			end
		endcase
		res = '0;
		res.status = drum;
		res.step = next_step;
		res.washing = running;
		res.drive = lines;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_word_t got;
		result_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				program_table[i] = '0;
			running = 1'b0;
			next_step = '0;
			step_left = '0;
			drum = STAT_NONE;
			drum_after = '0;
			drum_left = '0;
			step_mask = '0;
			lines = DRIVE_ALL_OFF;
			prog_sel = PROGRAM_SELECT_RST;
			run_len = RUN_TICKS_RST;
			pause_len = PAUSE_TICKS_RST;
			motor_bits = MOTOR_MASK_RST;
			reverse_bits = REVERSE_MASK_RST;
			expected_words.delete();
			errors = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PROGRAM_SELECT: prog_sel = cfg_data[PROG_W-1:0];
					CFG_RUN_TICKS:      run_len = cfg_data;
					CFG_PAUSE_TICKS:    pause_len = cfg_data;
					CFG_MOTOR_MASK:     motor_bits = cfg_data;
					CFG_REVERSE_MASK:   reverse_bits = cfg_data;
					default: ;
				endcase
			end
			// a result leaves only after its word was accepted, so compare before predicting
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: result expected none, got %0h", $time, m_axis_tdata);
				end else begin
					want = expected_words.pop_front();
					compare_field("drive_lines", 32'(want.drive), 32'(got.drive));
					compare_field("washing", 32'(want.washing), 32'(got.washing));
					compare_field("step_number", 32'(want.step), 32'(got.step));
					compare_field("rotation_status", 32'(want.status), 32'(got.status));
					compare_field("pad", 32'(want.pad), 32'(got.pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_word(op_t'(s_axis_tuser), s_axis_tdata, want);
				expected_words.push_back(want);
			end
			outstanding <= expected_words.size();
			mismatches <= errors;
		end
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the wash program sequencer: clock, reset, stimulus and verdict.
// Depends on wps_pkg, wash_program_sequencer_core and wash_sequencer_checker.
module tb_top;
	import wps_pkg::*;

	// cycles with no word moving on any channel before the run is called hung
	localparam int unsigned STALL_LIMIT       = 2000;
	localparam int          ITEMS_PER_SETTING = 295;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [S_TUSER_W-1:0]  s_axis_tuser  = OP_TICK;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_PROGRAM_SELECT;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// percent of cycles in which each side holds back
	int                    send_idle_pct = 30;
	int                    recv_idle_pct = 73;
	int                    outstanding;
	int                    mismatches;
	int unsigned           quiet_cycles  = 0;

	always #2 clk = ~clk;

	wash_program_sequencer_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	wash_sequencer_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	// Result side: drop tready at random, at the rate of the current phase.
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Watchdog: count cycles in which no word moves anywhere; give up at the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL wash_program_sequencer_core");
				$finish;
			end
		end
	end

	// Random bits for the data lanes that an operation ignores.
	function automatic logic [S_TDATA_W-1:0] filler();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[S_TDATA_W-1:0];
	endfunction

	// Pack a step entry write, address in the lowest bits.
	function automatic logic [S_TDATA_W-1:0] entry_word(input logic [TABLE_AW-1:0] addr,
			input logic stop_here, input logic spin, input logic [MASK_W-1:0] mask,
			input logic [DUR_W-1:0] ticks);
		return {ticks, mask, spin, stop_here, addr};
	endfunction

	// Mostly short steps so programs move on; now and then a step that never
	// runs out, which only an abort gets past.
	function automatic logic [DUR_W-1:0] random_duration();
		case ($urandom_range(0, 31))
			0:       return '1;
			1:       return $urandom;
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	// Present one word, idling first at the phase rate; return on the accepting edge
	// with tvalid still high so back-to-back words need no second assignment.
	task automatic send_word(input op_t op, input logic [S_TDATA_W-1:0] payload);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= payload;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop tvalid and hold until every predicted result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all five registers back to back; tvalid-style valid stays high between them.
	task automatic load_settings(input logic [PROG_W-1:0] prog,
			input logic [ROT_TICK_W-1:0] run_len, input logic [ROT_TICK_W-1:0] pause_len,
			input logic [MASK_W-1:0] motor, input logic [MASK_W-1:0] reverse);
		cfg_idx_t          reg_order [5];
		logic [CFG_DATA_W-1:0] vals  [5];
		reg_order[0] = CFG_PROGRAM_SELECT;
		reg_order[1] = CFG_RUN_TICKS;
		reg_order[2] = CFG_PAUSE_TICKS;
		reg_order[3] = CFG_MOTOR_MASK;
		reg_order[4] = CFG_REVERSE_MASK;
		vals[0] = {{(CFG_DATA_W-PROG_W){1'b0}}, prog};
		vals[1] = run_len;
		vals[2] = pause_len;
		vals[3] = motor;
		vals[4] = reverse;
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_order[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Write every table entry so no step read ever hits an unwritten slot.
	// Program 1 gets no end flags, so it runs into the step cap.
	task automatic fill_table();
		for (int a = 0; a < TABLE_DEPTH; a++)
			send_word(OP_WRITE, entry_word(a[TABLE_AW-1:0],
				(a / STEPS_DEF == 1) ? 1'b0 : ($urandom_range(0, 9) == 0),
				1'($urandom_range(0, 1)), 16'($urandom), random_duration()));
	endtask

	// Short directed pass on the reset register values.
	task automatic directed_checks();
		// tick with nothing running, abort while idle, then the stopping evaluation
		send_word(OP_TICK, filler());
		send_word(OP_ABORT, filler());
		send_word(OP_TICK, filler());
		// program 0: rotating all-on step of zero length, a quiet one-tick step, then end
		send_word(OP_WRITE, entry_word(6'd0, 1'b0, 1'b1, 16'hFFFF, 32'd0));
		send_word(OP_WRITE, entry_word(6'd1, 1'b0, 1'b0, 16'h0000, 32'd1));
		send_word(OP_WRITE, entry_word(6'd2, 1'b1, 1'b1, 16'h5A5A, 32'hFFFF_FFFF));
		send_word(OP_START, filler());
		repeat (4) send_word(OP_TICK, filler());
		// start again, then start while running
		send_word(OP_START, filler());
		send_word(OP_TICK, filler());
		send_word(OP_START, filler());
		send_word(OP_TICK, filler());
		// abort mid-run; the ticks after it must keep every line off
		send_word(OP_ABORT, filler());
		send_word(OP_TICK, filler());
		send_word(OP_TICK, filler());
		// top address, longest step
		send_word(OP_WRITE, entry_word(6'd63, 1'b0, 1'b1, 16'h8001, 32'hFFFF_FFFF));
	endtask

	// Mostly well-formed wash runs (optional abort, start, tick burst) with
	// stray ticks, entry rewrites, aborts and starts mixed in.
	task automatic random_traffic(input int n_items);
		int sent;
		int pick;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				if ($urandom_range(0, 3) == 0) begin
					send_word(OP_ABORT, filler());
					sent++;
				end
				send_word(OP_START, filler());
				sent++;
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 180) :
					$urandom_range(4, 40);
				if (burst > n_items - sent)
					burst = n_items - sent;
				repeat (burst) begin
					send_word(OP_TICK, filler());
					sent++;
				end
			end else if (pick < 80) begin
				burst = $urandom_range(1, 20);
				repeat (burst) begin
					send_word(OP_TICK, filler());
					sent++;
				end
			end else if (pick < 90) begin
				send_word(OP_WRITE, entry_word(6'($urandom_range(0, TABLE_DEPTH - 1)),
					$urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 16'($urandom),
					random_duration()));
				sent++;
			end else if (pick < 95) begin
				send_word(OP_ABORT, filler());
				sent++;
			end else begin
				send_word(OP_START, filler());
				sent++;
			end
		end
	endtask

	// Register settings per phase; extremes of every register appear among them.
	task automatic apply_setting(input int idx);
		case (idx)
			0: load_settings(2'd0, 16'd2, 16'd1, 16'h4000, 16'h8000);
			1: load_settings(2'd1, 16'd0, 16'd0, 16'hFFFF, 16'h0000);
			2: load_settings(2'd2, 16'hFFFF, 16'd3, 16'h0000, 16'hFFFF);
			3: load_settings(2'd3, 16'd5, 16'd2, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			4: load_settings(2'd1, 16'd1, 16'hFFFF, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			default: load_settings(2'($urandom_range(0, 3)), 16'($urandom_range(1, 9)),
				16'($urandom_range(1, 9)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
		endcase
	endtask

	initial begin
		// hold reset at the start, release it once and never again
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_table();
		directed_checks();
		drain();

		// two settings per idling pattern: sender light / receiver heavy,
		// then the other way round, then no idling at all
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 73;
				recv_idle_pct <= 30;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			apply_setting(ph);
			random_traffic(ITEMS_PER_SETTING);
			drain();
		end

		if (mismatches == 0)
			$display("PASS wash_program_sequencer_core");
		else
			$display("FAIL wash_program_sequencer_core");
		$finish;
	end

endmodule

### sim.f
src/wps_pkg.sv
src/wps_ram.sv
src/wash_program_sequencer_core.sv
dv/wash_sequencer_checker.sv
dv/tb_top.sv
